// ----- hdl/mvm_pkg.sv -----
// Shared types and constants for the matrix-vector multiply-accumulate block.
// No dependencies; every other file of the block except mvm_ram refers to this package.
package mvm_pkg;

  localparam int unsigned COL_W      = 10;   // reach of col_index
  localparam int unsigned VAL_W      = 16;   // Q8.8 operand
  localparam int unsigned PROD_W     = 2 * VAL_W;  // Q16.16 product
  localparam int unsigned SUM_W      = 48;   // Q32.16 accumulator
  localparam int unsigned ROW_W      = 16;   // row counter and row_index
  localparam int unsigned COLS_REG_W = 11;
  localparam int unsigned ROWS_REG_W = 17;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned COL_REACH  = 1 << COL_W;
  localparam int unsigned ROW_REACH  = 1 << ROW_W;

  localparam int unsigned MAX_COLS_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF = 65536;

  localparam logic [COLS_REG_W-1:0] COLS_RESET = COLS_REG_W'(1024);
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = ROWS_REG_W'(65536);

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS = 8'd0,
    CFG_ROWS = 8'd1
  } cfg_reg_e;

  typedef enum logic {
    REQ_VECTOR = 1'b0,
    REQ_MATRIX = 1'b1
  } req_type_e;

  // One multiply-accumulate operation handed from the front to the back.
  typedef struct packed {
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic                    last_col;
  } mvm_op_t;

endpackage

// ----- hdl/mvm_if.sv -----
// Valid/ready channel interfaces: input items, result items, configuration writes.
// Depends on mvm_pkg for field widths.
interface mvm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [mvm_pkg::COL_W-1:0]           col_index;
  logic signed [mvm_pkg::VAL_W-1:0]    value;
  modport source (output valid, req_type, col_index, value, input ready);
  modport sink   (input valid, req_type, col_index, value, output ready);
endinterface

interface mvm_out_if;
  logic                                valid;
  logic                                ready;
  logic [mvm_pkg::ROW_W-1:0]           row_index;
  logic signed [mvm_pkg::SUM_W-1:0]    row_sum;
  logic                                last_row;
  logic                                saturated;
  modport source (output valid, row_index, row_sum, last_row, saturated, input ready);
  modport sink   (input valid, row_index, row_sum, last_row, saturated, output ready);
endinterface

interface mvm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mvm_pkg::CFG_IDX_W-1:0]       index;
  logic [mvm_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/matrix_vector_multiply_accumulate.sv -----
// A row result is offered once its last-column element has passed the RAM read and operand
// register, the queue, the product register and the result register. Throughput: one item
// per cycle unless back-pressure stalls the path; the single multiply-accumulate unit takes
// one element per cycle. Reset clears control state and sets cols_in_use to 1024 and
// rows_in_use to 65536; the vector store holds no defined contents until written.
module matrix_vector_multiply_accumulate #(
  parameter int unsigned MAX_COLS = mvm_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = mvm_pkg::MAX_ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mvm_in_if.sink     in_req_i,
  mvm_cfg_if.sink    cfg_i,
  mvm_out_if.source  res_o
);

  // Effective limits: the store cannot exceed the reach of col_index, the row
  // count cannot exceed the reach of the row counter.
  localparam int unsigned COL_LIM = (MAX_COLS < mvm_pkg::COL_REACH) ? MAX_COLS
                                                                    : mvm_pkg::COL_REACH;
  localparam int unsigned ROW_LIM = (MAX_ROWS < mvm_pkg::ROW_REACH) ? MAX_ROWS
                                                                    : mvm_pkg::ROW_REACH;
  localparam int unsigned CW = mvm_pkg::COLS_REG_W;
  localparam int unsigned RW = mvm_pkg::ROWS_REG_W;

  logic [CW-1:0]               cols_q;
  logic [RW-1:0]               rows_q;
  logic [CW-1:0]               cols_eff;
  logic [RW-1:0]               rows_eff;
  logic [CW-1:0]               cols_eff_m1;
  logic [RW-1:0]               rows_eff_m1;
  logic                        cfg_wr;

  logic                        op_valid;
  logic                        op_ready;
  mvm_pkg::mvm_op_t            op;
  logic                        q_valid;
  logic                        q_ready;
  mvm_pkg::mvm_op_t            q_op;

  // Configuration writes: always ready, unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= mvm_pkg::COLS_RESET;
      rows_q <= mvm_pkg::ROWS_RESET;
    end else if (cfg_wr) begin
      case (cfg_i.index)
        mvm_pkg::CFG_COLS: cols_q <= cfg_i.data[CW-1:0];
        mvm_pkg::CFG_ROWS: rows_q <= cfg_i.data[RW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the counts: zero acts as one, anything above the limit as the limit.
  always_comb begin
    if (cols_q == '0) begin
      cols_eff = CW'(1);
    end else if (cols_q > CW'(COL_LIM)) begin
      cols_eff = CW'(COL_LIM);
    end else begin
      cols_eff = cols_q;
    end
    if (rows_q == '0) begin
      rows_eff = RW'(1);
    end else if (rows_q > RW'(ROW_LIM)) begin
      rows_eff = RW'(ROW_LIM);
    end else begin
      rows_eff = rows_q;
    end
  end

  assign cols_eff_m1 = cols_eff - 1'b1;
  assign rows_eff_m1 = rows_eff - 1'b1;

  // Front end: classify, write the vector store, fetch b[j].
  mvm_front #(
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_req_i),
    .ncols_m1_i(cols_eff_m1[mvm_pkg::COL_W-1:0]),
    .op_valid_o(op_valid),
    .op_ready_i(op_ready),
    .op_o      (op)
  );

  // Decouple the front from result back-pressure.
  mvm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(op_valid),
    .push_ready_o(op_ready),
    .push_data_i (op),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (q_op)
  );

  // Back end: multiply, accumulate with saturation, emit row results.
  mvm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_valid_i(q_valid),
    .op_ready_o(q_ready),
    .op_i      (q_op),
    .nrows_m1_i(rows_eff_m1[mvm_pkg::ROW_W-1:0]),
    .res_o     (res_o)
  );

  a_counts_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cols_eff != '0 && cols_eff <= CW'(COL_LIM) && rows_eff != '0 && rows_eff <= RW'(ROW_LIM))
    else $error("effective counts out of range");

endmodule

// ----- hdl/mvm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mvm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/mvm_front.sv -----
// Front end: accepts input transactions, writes vector entries, looks up b[j]
// for matrix elements and hands operations on. Depends on mvm_pkg, mvm_if, mvm_ram.
module mvm_front #(
  parameter int unsigned MAX_COLS = mvm_pkg::MAX_COLS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mvm_in_if.sink                     in_i,
  input  logic [mvm_pkg::COL_W-1:0]  ncols_m1_i,
  output logic                       op_valid_o,
  input  logic                       op_ready_i,
  output mvm_pkg::mvm_op_t           op_o
);

  localparam int unsigned DEPTH  = (MAX_COLS < mvm_pkg::COL_REACH) ? MAX_COLS
                                                                   : mvm_pkg::COL_REACH;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic                              accept;
  logic                              is_vec;
  logic                              vec_wr;
  logic                              mat_rd;
  logic                              s1_valid_q, s1_valid_d;
  logic signed [mvm_pkg::VAL_W-1:0]  s1_a_q;
  logic                              s1_last_q;
  logic [mvm_pkg::VAL_W-1:0]         b_rdata;

  assign in_i.ready = !s1_valid_q || op_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign is_vec     = (in_i.req_type == mvm_pkg::REQ_VECTOR);
  // drop loads beyond the store and elements beyond the columns in use
  assign vec_wr = accept && is_vec &&
                  ({1'b0, in_i.col_index} < (mvm_pkg::COL_W+1)'(DEPTH));
  assign mat_rd = accept && !is_vec && (in_i.col_index <= ncols_m1_i);

  mvm_ram #(
    .WIDTH(mvm_pkg::VAL_W),
    .DEPTH(DEPTH)
  ) u_vec_ram (
    .clk_i  (clk_i),
    .we_i   (vec_wr),
    .waddr_i(in_i.col_index[ADDR_W-1:0]),
    .wdata_i(in_i.value),
    .re_i   (mat_rd),
    .raddr_i(in_i.col_index[ADDR_W-1:0]),
    .rdata_o(b_rdata)
  );

  always_comb begin
    if (mat_rd) begin
      s1_valid_d = 1'b1;
    end else if (op_ready_i) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mat_rd) begin
      s1_a_q    <= in_i.value;
      s1_last_q <= (in_i.col_index == ncols_m1_i);
    end
  end

  assign op_valid_o  = s1_valid_q;
  assign op_o.a        = s1_a_q;
  assign op_o.b        = b_rdata;
  assign op_o.last_col = s1_last_q;

  // a stalled operation keeps its operands, including the RAM read data
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !op_ready_i |=> s1_valid_q && $stable(s1_a_q) && $stable(b_rdata))
    else $error("front stage lost a stalled operation");

endmodule

// ----- hdl/mvm_queue.sv -----
// Short FIFO of operations between the front and back ends.
// Depends on mvm_pkg.
module mvm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  mvm_pkg::mvm_op_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output mvm_pkg::mvm_op_t pop_data_o
);

  localparam int unsigned DEPTH = mvm_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mvm_pkg::mvm_op_t  buf_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue occupancy out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) || (count_q == CNT_W'(DEPTH)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with occupancy");

endmodule

// ----- hdl/mvm_back.sv -----
// Back end: multiply, saturating accumulate, row bookkeeping and result register.
// Depends on mvm_pkg and mvm_if.
module mvm_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       op_valid_i,
  output logic                       op_ready_o,
  input  mvm_pkg::mvm_op_t           op_i,
  input  logic [mvm_pkg::ROW_W-1:0]  nrows_m1_i,
  mvm_out_if.source                  res_o
);

  localparam int unsigned PW = mvm_pkg::PROD_W;
  localparam int unsigned SW = mvm_pkg::SUM_W;
  localparam logic signed [SW-1:0] ACC_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] ACC_MIN = {1'b1, {(SW-1){1'b0}}};

  logic                              m_valid_q, m_valid_d;
  logic signed [PW-1:0]              m_prod_q;
  logic                              m_last_q;
  logic                              out_block;
  logic                              m_fire;
  logic                              pop;

  logic signed [SW-1:0]              acc_q;
  logic                              ovf_q;
  logic [mvm_pkg::ROW_W-1:0]         row_cnt_q;
  logic signed [SW:0]                sum_wide;
  logic signed [SW-1:0]              sum_sat;
  logic                              ovf_now;
  logic                              is_last_row;

  logic                              out_valid_q, out_valid_d;
  logic [mvm_pkg::ROW_W-1:0]         out_row_q;
  logic signed [SW-1:0]              out_sum_q;
  logic                              out_last_q;
  logic                              out_sat_q;

  assign out_block  = out_valid_q && !res_o.ready;
  assign m_fire     = m_valid_q && !(m_last_q && out_block);
  assign op_ready_o = !m_valid_q || m_fire;
  assign pop        = op_valid_i && op_ready_o;

  assign sum_wide = {acc_q[SW-1], acc_q} + (SW+1)'(m_prod_q);
  assign ovf_now  = (sum_wide[SW] != sum_wide[SW-1]);
  assign sum_sat  = !ovf_now ? sum_wide[SW-1:0] : (sum_wide[SW] ? ACC_MIN : ACC_MAX);
  assign is_last_row = (row_cnt_q >= nrows_m1_i);

  always_comb begin
    m_valid_d = pop ? 1'b1 : (m_fire ? 1'b0 : m_valid_q);
    out_valid_d = out_valid_q && !res_o.ready;
    if (m_fire && m_last_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      row_cnt_q   <= '0;
    end else begin
      m_valid_q   <= m_valid_d;
      out_valid_q <= out_valid_d;
      if (m_fire) begin
        if (m_last_q) begin
          acc_q     <= '0;
          ovf_q     <= 1'b0;
          row_cnt_q <= is_last_row ? '0 : row_cnt_q + 1'b1;
        end else begin
          acc_q <= sum_sat;
          ovf_q <= ovf_q | ovf_now;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      m_prod_q <= op_i.a * op_i.b;
      m_last_q <= op_i.last_col;
    end
    if (m_fire && m_last_q) begin
      out_row_q  <= row_cnt_q;
      out_sum_q  <= sum_sat;
      out_last_q <= is_last_row;
      out_sat_q  <= ovf_q | ovf_now;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.row_index = out_row_q;
  assign res_o.row_sum   = out_sum_q;
  assign res_o.last_row  = out_last_q;
  assign res_o.saturated = out_sat_q;

  a_row_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_fire && m_last_q |=> acc_q == '0 && !ovf_q)
    else $error("accumulator not cleared after a row");

  a_row_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_fire && m_last_q && !is_last_row |=> row_cnt_q == $past(row_cnt_q) + 1'b1)
    else $error("row counter did not advance");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_block |=> out_valid_q && $stable(out_sum_q) && $stable(out_row_q))
    else $error("pending result overwritten");

endmodule
